@@ hw/rtl/jrq_pkg.sv @@
`default_nettype none

package jrq_pkg;

	// most jobs handed out by one run word
	localparam logic [4:0] MAX_RESULTS = 5'd16;

	// capacity after reset
	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	// input word action codes
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_RUN     = 1'b1;

	// result kinds
	localparam logic KIND_ENQUEUE = 1'b0;
	localparam logic KIND_RUN     = 1'b1;

	// overflow policy codes
	localparam logic POLICY_REFUSE      = 1'b0;
	localparam logic POLICY_DROP_OLDEST = 1'b1;

	// config register indexes
	localparam logic REG_POLICY   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/job_ring_queue_with_overflow_policy.sv @@
`default_nettype none

// Enqueue word: its acknowledgement is on the result ports the cycle after start.
// Run word: one dispatched job per cycle, set by the single read port of the slot memory;
//   first result the cycle after start, busy held until the last job of the run is read.
// Empty run: one result, the cycle after start. The receiver cannot stall results.
// Reset: pointers, occupancy, totals and policy cleared, capacity 16; slot memory not cleared.
module job_ring_queue_with_overflow_policy
	import jrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// command side
	input  wire                start,
	output logic               busy,
	input  wire                action,
	input  wire  [31:0]        job_handle,
	input  wire  [31:0]        job_context,
	input  wire  [4:0]         max_count,
	// config write port
	input  wire                wr_en,
	input  wire                wr_index,
	input  wire  [4:0]         wr_data,
	// result side
	output logic               result_strobe,
	output logic               result_kind,
	output logic               accepted,
	output logic               job_valid,
	output logic [31:0]        out_handle,
	output logic [31:0]        out_context,
	output logic               last_of_run,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count,
	output logic [31:0]        enqueued_total,
	output logic [31:0]        dropped_total,
	output logic [31:0]        dropped_oldest_total,
	output logic [31:0]        executed_total
);

	// pointer width, occupancy width, and a common compare width that also covers
	// the 5-bit capacity register
	localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CAPW = (CW > 5) ? CW : 5;

	// ---------------- state ----------------
	state_t          state_q, state_d;
	logic [PW-1:0]   rptr_q, rptr_d;
	logic [PW-1:0]   wptr_q, wptr_d;
	logic [CW-1:0]   occ_q, occ_d;
	logic [4:0]      rem_q, rem_d;      // jobs still to hand out in this run
	logic [31:0]     enq_cnt_q, enq_cnt_d;
	logic [31:0]     refuse_cnt_q, refuse_cnt_d;
	logic [31:0]     discard_cnt_q, discard_cnt_d;
	logic [31:0]     exec_cnt_q, exec_cnt_d;
	logic            policy_q, policy_d;
	logic [4:0]      cap_q, cap_d;

	// result flags, shown the cycle after they are decided
	logic            strobe_q, strobe_d;
	logic            kind_q, kind_d;
	logic            acc_q, acc_d;
	logic            jv_q, jv_d;
	logic            last_q, last_d;

	// slot memory: {context, handle}, one write and one registered read port
	logic [63:0]     slot_mem [QUEUE_DEPTH];
	logic [63:0]     rd_data_q;
	logic            mem_we;
	logic            mem_re;

	// ---------------- combinational helpers ----------------
	logic            accept;
	logic            is_enq;
	logic            full;
	logic            dispatch;
	logic [CAPW-1:0] cap_eff;
	logic [CAPW-1:0] cap_ext;
	logic [CAPW-1:0] occ_ext;
	logic [4:0]      req_c;
	logic [4:0]      n_run;
	logic [4:0]      rem_after;

	// next ring position, wrapping at the capacity in use
	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
	                                            input logic [CAPW-1:0] cap);
		logic [CAPW:0] n;
		n = (CAPW+1)'(p) + (CAPW+1)'(1);
		return (n >= {1'b0, cap}) ? '0 : n[PW-1:0];
	endfunction

	always_comb begin
		// capacity of zero acts as one, above the built depth acts as the depth
		cap_ext = CAPW'(cap_q);
		if (cap_q == 5'd0) begin
			cap_eff = CAPW'(1);
		end else if (cap_ext > CAPW'(QUEUE_DEPTH)) begin
			cap_eff = CAPW'(QUEUE_DEPTH);
		end else begin
			cap_eff = cap_ext;
		end

		occ_ext = CAPW'(occ_q);
		full    = (occ_ext >= cap_eff);
		busy    = (state_q == ST_RUN);
		accept  = start && !busy;
		is_enq  = (action == ACT_ENQUEUE);

		// jobs this run hands out: min(limited request, occupancy)
		req_c = (max_count > MAX_RESULTS) ? MAX_RESULTS : max_count;
		n_run = (CAPW'(req_c) < occ_ext) ? req_c : occ_ext[4:0];

		// first job is read in the accept cycle, the rest one per busy cycle
		dispatch  = (accept && !is_enq && (n_run != 5'd0)) || busy;
		rem_after = busy ? (rem_q - 5'd1) : (n_run - 5'd1);
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d       = state_q;
		rptr_d        = rptr_q;
		wptr_d        = wptr_q;
		occ_d         = occ_q;
		rem_d         = rem_q;
		enq_cnt_d     = enq_cnt_q;
		refuse_cnt_d  = refuse_cnt_q;
		discard_cnt_d = discard_cnt_q;
		exec_cnt_d    = exec_cnt_q;
		policy_d      = policy_q;
		cap_d         = cap_q;
		strobe_d      = 1'b0;
		kind_d        = kind_q;
		acc_d         = 1'b0;
		jv_d          = 1'b0;
		last_d        = 1'b1;
		mem_we        = 1'b0;
		mem_re        = 1'b0;

		if (accept && is_enq) begin
			strobe_d = 1'b1;
			kind_d   = KIND_ENQUEUE;
			// null handle: refused, nothing counted
			if (job_handle != 32'd0) begin
				if (full && (policy_q == POLICY_REFUSE)) begin
					refuse_cnt_d = refuse_cnt_q + 32'd1;
				end else begin
					acc_d     = 1'b1;
					mem_we    = 1'b1;
					wptr_d    = ring_next(wptr_q, cap_eff);
					enq_cnt_d = enq_cnt_q + 32'd1;
					if (full) begin
						// drop oldest: occupancy stays the same
						rptr_d        = ring_next(rptr_q, cap_eff);
						discard_cnt_d = discard_cnt_q + 32'd1;
					end else begin
						occ_d = occ_q + CW'(1);
					end
				end
			end
		end else if (dispatch) begin
			mem_re     = 1'b1;
			strobe_d   = 1'b1;
			kind_d     = KIND_RUN;
			jv_d       = 1'b1;
			rptr_d     = ring_next(rptr_q, cap_eff);
			occ_d      = occ_q - CW'(1);
			exec_cnt_d = exec_cnt_q + 32'd1;
			rem_d      = rem_after;
			last_d     = (rem_after == 5'd0);
			state_d    = (rem_after == 5'd0) ? ST_IDLE : ST_RUN;
		end else if (accept) begin
			// run with nothing to hand out: one empty result
			strobe_d = 1'b1;
			kind_d   = KIND_RUN;
		end

		if (wr_en) begin
			case (wr_index)
				REG_POLICY: begin
					policy_d = wr_data[0];
				end
				REG_CAPACITY: begin
					// new capacity empties the queue, totals kept
					cap_d  = wr_data;
					rptr_d = '0;
					wptr_d = '0;
					occ_d  = '0;
				end
				default: begin
					policy_d = policy_q;
				end
			endcase
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rptr_q        <= '0;
			wptr_q        <= '0;
			occ_q         <= '0;
			rem_q         <= '0;
			enq_cnt_q     <= '0;
			refuse_cnt_q  <= '0;
			discard_cnt_q <= '0;
			exec_cnt_q    <= '0;
			policy_q      <= POLICY_REFUSE;
			cap_q         <= CAPACITY_RESET;
			strobe_q      <= 1'b0;
			kind_q        <= KIND_ENQUEUE;
			acc_q         <= 1'b0;
			jv_q          <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			rptr_q        <= rptr_d;
			wptr_q        <= wptr_d;
			occ_q         <= occ_d;
			rem_q         <= rem_d;
			enq_cnt_q     <= enq_cnt_d;
			refuse_cnt_q  <= refuse_cnt_d;
			discard_cnt_q <= discard_cnt_d;
			exec_cnt_q    <= exec_cnt_d;
			policy_q      <= policy_d;
			cap_q         <= cap_d;
			strobe_q      <= strobe_d;
			kind_q        <= kind_d;
			acc_q         <= acc_d;
			jv_q          <= jv_d;
			last_q        <= last_d;
		end
	end

	// slot memory; reads and writes never target the same cycle, since reads
	// only happen while a run is dispatching and writes only on an enqueue
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[wptr_q] <= {job_context, job_handle};
		end
		if (mem_re) begin
			rd_data_q <= slot_mem[rptr_q];
		end
	end

	// ---------------- result word ----------------
	// totals and occupancy registers already hold the values after this result
	assign result_strobe        = strobe_q;
	assign result_kind          = kind_q;
	assign accepted             = acc_q;
	assign job_valid            = jv_q;
	assign out_handle           = jv_q ? rd_data_q[31:0] : 32'd0;
	assign out_context          = jv_q ? rd_data_q[63:32] : 32'd0;
	assign last_of_run          = last_q;
	assign pending_count        = occ_q;
	assign enqueued_total       = enq_cnt_q;
	assign dropped_total        = refuse_cnt_q;
	assign dropped_oldest_total = discard_cnt_q;
	assign executed_total       = exec_cnt_q;

	// ---------------- assertions ----------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CAPW'(occ_q) <= cap_eff)
		else $error("occupancy above capacity in use");

	a_run_has_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rem_q != 5'd0) && (CAPW'(occ_q) >= CAPW'(rem_q)))
		else $error("run in progress without enough queued jobs");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_of_run) |-> !busy)
		else $error("last result shown while still dispatching");

	a_job_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && job_valid) |-> (result_kind == KIND_RUN) && !accepted)
		else $error("dispatched job flagged on an enqueue result");

	a_busy_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> result_strobe)
		else $error("dispatch cycle produced no result");

endmodule

`default_nettype wire
